[rtl/core/sit_pkg.sv]
// Shared types for the segment intersection test pipeline.
`default_nettype none

package sit_pkg;

  // Load enables for the two register stages of one cross-product unit.
  typedef struct packed {
    logic prod_en;
    logic diff_en;
  } cross_en_t;

endpackage

`default_nettype wire

[rtl/core/segment_intersection_test.sv]
// Top level: pipelined exact test of whether two 2D line segments intersect.
// An accepted input beat passes through stages 1 to 4 before its result beat appears on the output.
// Throughput: one segment pair per cycle while the output is not stalled, set by the four load-enabled register stages.
// Each stage holds its beat only while the stage after it is full and stalled.
// Reset (rst_ni low, asynchronous) clears the stage valid bits; data registers keep junk.
`default_nettype none

module segment_intersection_test #(
  parameter int COORD_BITS = 16
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  // Slave side: one segment pair per beat.
  input  wire                        s_axis_tvalid,
  output logic                       s_axis_tready,
  // From bit 0 up: seg_a_x0, seg_a_y0, seg_a_x1, seg_a_y1,
  // seg_b_x0, seg_b_y0, seg_b_x1, seg_b_y1, each COORD_BITS wide, two's complement.
  input  wire [8*COORD_BITS-1:0]     s_axis_tdata,
  // Master side: one result per accepted pair.
  output logic                       m_axis_tvalid,
  input  wire                        m_axis_tready,
  // From bit 0 up: hit, then seven zero bits.
  output logic [7:0]                 m_axis_tdata
);

  // Coordinate differences need one bit more than the coordinates; the cross
  // products built from them need twice that plus one.
  localparam int DW = COORD_BITS + 1;
  localparam int CW = 2 * DW + 1;

  // Per-stage valid bits and load enables. A stage loads when it is empty or
  // when the stage after it is moving, so bubbles are squeezed out under stall.
  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;

  assign en4 = !v4_q || m_axis_tready;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;

  assign s_axis_tready = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= s_axis_tvalid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: unpack, form the coordinate differences and the bounding-range test.
  // ---------------------------------------------------------------------------
  logic signed [COORD_BITS-1:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;

  assign ax0 = s_axis_tdata[0*COORD_BITS +: COORD_BITS];
  assign ay0 = s_axis_tdata[1*COORD_BITS +: COORD_BITS];
  assign ax1 = s_axis_tdata[2*COORD_BITS +: COORD_BITS];
  assign ay1 = s_axis_tdata[3*COORD_BITS +: COORD_BITS];
  assign bx0 = s_axis_tdata[4*COORD_BITS +: COORD_BITS];
  assign by0 = s_axis_tdata[5*COORD_BITS +: COORD_BITS];
  assign bx1 = s_axis_tdata[6*COORD_BITS +: COORD_BITS];
  assign by1 = s_axis_tdata[7*COORD_BITS +: COORD_BITS];

  logic signed [DW-1:0] dax_d, day_d, dbx_d, dby_d, wx_d, wy_d, ex_d, ey_d;
  logic signed [DW-1:0] dax_q, day_q, dbx_q, dby_q, wx_q, wy_q, ex_q, ey_q;

  // Differences are taken on sign-extended operands, so they never wrap.
  assign dax_d = {ax1[COORD_BITS-1], ax1} - {ax0[COORD_BITS-1], ax0};
  assign day_d = {ay1[COORD_BITS-1], ay1} - {ay0[COORD_BITS-1], ay0};
  assign dbx_d = {bx1[COORD_BITS-1], bx1} - {bx0[COORD_BITS-1], bx0};
  assign dby_d = {by1[COORD_BITS-1], by1} - {by0[COORD_BITS-1], by0};
  assign wx_d  = {bx0[COORD_BITS-1], bx0} - {ax0[COORD_BITS-1], ax0};
  assign wy_d  = {by0[COORD_BITS-1], by0} - {ay0[COORD_BITS-1], ay0};
  assign ex_d  = {bx1[COORD_BITS-1], bx1} - {ax0[COORD_BITS-1], ax0};
  assign ey_d  = {by1[COORD_BITS-1], by1} - {ay0[COORD_BITS-1], ay0};

  // Two closed intervals overlap when each one's low end is not above the
  // other's high end. Endpoints are ordered first, since either may be larger.
  logic signed [COORD_BITS-1:0] alo_x, ahi_x, blo_x, bhi_x;
  logic signed [COORD_BITS-1:0] alo_y, ahi_y, blo_y, bhi_y;
  logic                         range_ok_d, range_ok1_q;

  assign alo_x = (ax0 < ax1) ? ax0 : ax1;
  assign ahi_x = (ax0 < ax1) ? ax1 : ax0;
  assign blo_x = (bx0 < bx1) ? bx0 : bx1;
  assign bhi_x = (bx0 < bx1) ? bx1 : bx0;
  assign alo_y = (ay0 < ay1) ? ay0 : ay1;
  assign ahi_y = (ay0 < ay1) ? ay1 : ay0;
  assign blo_y = (by0 < by1) ? by0 : by1;
  assign bhi_y = (by0 < by1) ? by1 : by0;

  assign range_ok_d = (alo_x <= bhi_x) && (blo_x <= ahi_x) &&
                      (alo_y <= bhi_y) && (blo_y <= ahi_y);

  always_ff @(posedge clk_i) begin
    if (en1) begin
      dax_q       <= dax_d;
      day_q       <= day_d;
      dbx_q       <= dbx_d;
      dby_q       <= dby_d;
      wx_q        <= wx_d;
      wy_q        <= wy_d;
      ex_q        <= ex_d;
      ey_q        <= ey_d;
      range_ok1_q <= range_ok_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 2 and 3: four cross-product units, products then differences.
  //   den = d_a x d_b          determinant of the two directions
  //   tn  = w x d_b            position along segment a, scaled by den
  //   un  = w x d_a            position along segment b, scaled by den
  //   col = d_a x (b1 - a0)    collinearity of the far end of segment b
  // When den is zero, un == 0 means b0 lies on line a, and when segment a is
  // a single point, tn == 0 means that point lies on line b.
  // ---------------------------------------------------------------------------
  sit_pkg::cross_en_t cross_en;

  assign cross_en.prod_en = en2;
  assign cross_en.diff_en = en3;

  logic signed [CW-1:0] den, tn, un, col;

  sit_cross #(.OP_BITS(DW)) u_cross_den (
    .clk_i   (clk_i),
    .en_i    (cross_en),
    .ux_i    (dax_q),
    .uy_i    (day_q),
    .vx_i    (dbx_q),
    .vy_i    (dby_q),
    .cross_o (den)
  );

  sit_cross #(.OP_BITS(DW)) u_cross_tn (
    .clk_i   (clk_i),
    .en_i    (cross_en),
    .ux_i    (wx_q),
    .uy_i    (wy_q),
    .vx_i    (dbx_q),
    .vy_i    (dby_q),
    .cross_o (tn)
  );

  sit_cross #(.OP_BITS(DW)) u_cross_un (
    .clk_i   (clk_i),
    .en_i    (cross_en),
    .ux_i    (wx_q),
    .uy_i    (wy_q),
    .vx_i    (dax_q),
    .vy_i    (day_q),
    .cross_o (un)
  );

  sit_cross #(.OP_BITS(DW)) u_cross_col (
    .clk_i   (clk_i),
    .en_i    (cross_en),
    .ux_i    (dax_q),
    .uy_i    (day_q),
    .vx_i    (ex_q),
    .vy_i    (ey_q),
    .cross_o (col)
  );

  // Side flags travel beside the cross products so they stay aligned.
  logic a_pt2_q, b_pt2_q, range_ok2_q;
  logic a_pt3_q, b_pt3_q, range_ok3_q;

  always_ff @(posedge clk_i) begin
    if (en2) begin
      a_pt2_q     <= (dax_q == '0) && (day_q == '0);
      b_pt2_q     <= (dbx_q == '0) && (dby_q == '0);
      range_ok2_q <= range_ok1_q;
    end
    if (en3) begin
      a_pt3_q     <= a_pt2_q;
      b_pt3_q     <= b_pt2_q;
      range_ok3_q <= range_ok2_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: decision. For crossing lines both scaled parameters must lie in
  // [0, den] when den is positive, or in [den, 0] when den is negative, which
  // avoids a division. For parallel lines the segments must be collinear and
  // their bounding ranges must overlap.
  // ---------------------------------------------------------------------------
  logic den_nz, cross_hit, par_hit, hit_d, hit_q;

  assign den_nz = (den != '0);

  always_comb begin
    if (!den[CW-1]) begin
      cross_hit = (tn >= 0) && (tn <= den) && (un >= 0) && (un <= den);
    end else begin
      cross_hit = (tn <= 0) && (tn >= den) && (un <= 0) && (un >= den);
    end

    if (!a_pt3_q) begin
      par_hit = (un == '0) && (col == '0) && range_ok3_q;
    end else if (!b_pt3_q) begin
      par_hit = (tn == '0) && range_ok3_q;
    end else begin
      // Two single points meet only when equal, which the range test decides.
      par_hit = range_ok3_q;
    end

    hit_d = den_nz ? cross_hit : par_hit;
  end

  always_ff @(posedge clk_i) begin
    if (en4) begin
      hit_q <= hit_d;
    end
  end

  assign m_axis_tvalid = v4_q;
  assign m_axis_tdata  = {7'b0, hit_q};

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------

  // The input side may only be held off by a full pipe behind a stalled output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled while the output is free");

  // An accepted beat always lands in the first stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> v1_q)
    else $error("accepted beat lost at the first stage");

  // Two point segments give zero cross products: checks flag and data alignment.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && a_pt3_q && b_pt3_q) |-> ((den == '0) && (tn == '0) && (un == '0)))
    else $error("point flags out of step with the cross products");

  // A held result beat stays valid until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v4_q && !m_axis_tready) |=> (v4_q && $stable(hit_q)))
    else $error("stalled result changed");

endmodule

`default_nettype wire

[rtl/core/sit_cross.sv]
// Two-stage cross-product unit: registered products, then registered difference.
`default_nettype none

module sit_cross #(
  parameter int OP_BITS = 17
) (
  input  wire                              clk_i,
  input  wire sit_pkg::cross_en_t          en_i,
  input  wire logic signed [OP_BITS-1:0]   ux_i,
  input  wire logic signed [OP_BITS-1:0]   uy_i,
  input  wire logic signed [OP_BITS-1:0]   vx_i,
  input  wire logic signed [OP_BITS-1:0]   vy_i,
  output logic signed [2*OP_BITS:0]        cross_o
);

  localparam int PW = 2 * OP_BITS;

  logic signed [PW-1:0] ux_w, uy_w, vx_w, vy_w;
  logic signed [PW-1:0] prod_a_d, prod_b_d, prod_a_q, prod_b_q;
  logic signed [PW:0]   cross_d, cross_q;

  assign ux_w = {{OP_BITS{ux_i[OP_BITS-1]}}, ux_i};
  assign uy_w = {{OP_BITS{uy_i[OP_BITS-1]}}, uy_i};
  assign vx_w = {{OP_BITS{vx_i[OP_BITS-1]}}, vx_i};
  assign vy_w = {{OP_BITS{vy_i[OP_BITS-1]}}, vy_i};

  // The products fit exactly in twice the operand width.
  assign prod_a_d = ux_w * vy_w;
  assign prod_b_d = uy_w * vx_w;

  assign cross_d = {prod_a_q[PW-1], prod_a_q} - {prod_b_q[PW-1], prod_b_q};

  always_ff @(posedge clk_i) begin
    if (en_i.prod_en) begin
      prod_a_q <= prod_a_d;
      prod_b_q <= prod_b_d;
    end
    if (en_i.diff_en) begin
      cross_q <= cross_d;
    end
  end

  assign cross_o = cross_q;

endmodule

`default_nettype wire

[dv/tb_segment_intersection_test.sv]
// Self-checking testbench for the pipelined segment intersection test block.
`timescale 1ns / 1ps

// One segment pair as it travels on s_axis_tdata. The last member sits in the
// lowest bits, so from bit 0 up the layout is a_x0, a_y0, a_x1, a_y1, b_x0,
// b_y0, b_x1, b_y1, each 16 bits wide and two's complement.
typedef struct packed {
  logic signed [15:0] b_y1;
  logic signed [15:0] b_x1;
  logic signed [15:0] b_y0;
  logic signed [15:0] b_x0;
  logic signed [15:0] a_y1;
  logic signed [15:0] a_x1;
  logic signed [15:0] a_y0;
  logic signed [15:0] a_x0;
} seg_pair_t;

// Keeps the expected hit flags in the order the pairs went in and compares
// every result beat against the oldest one.
class intersect_scoreboard;
  localparam int unsigned MAX_REPORTS = 10;

  bit          expected_hits[$];
  int unsigned pairs_seen;
  int unsigned hits_seen;
  int unsigned mismatches;

  // Closed intervals [a,b] and [c,d], each given in either order.
  function bit spans_meet(longint a, longint b, longint c, longint d);
    longint lo1, hi1, lo2, hi2;
    lo1 = (a < b) ? a : b;
    hi1 = (a < b) ? b : a;
    lo2 = (c < d) ? c : d;
    hi2 = (c < d) ? d : c;
    return ((lo1 > lo2) ? lo1 : lo2) <= ((hi1 < hi2) ? hi1 : hi2);
  endfunction

  // Exact integer test: the products need at most 35 bits, so longint
  // holds every intermediate value without overflow.
  function bit predict_hit(seg_pair_t p);
    longint ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
    longint dax, day, dbx, dby, wx, wy, den, tn, un;
    ax0 = p.a_x0; ay0 = p.a_y0; ax1 = p.a_x1; ay1 = p.a_y1;
    bx0 = p.b_x0; by0 = p.b_y0; bx1 = p.b_x1; by1 = p.b_y1;
    dax = ax1 - ax0;
    day = ay1 - ay0;
    dbx = bx1 - bx0;
    dby = by1 - by0;
    wx  = bx0 - ax0;
    wy  = by0 - ay0;
    den = dax * dby - day * dbx;
    if (den != 0) begin
      // The crossing point is at fraction tn/den along a and un/den along b.
      tn = wx * dby - wy * dbx;
      un = wx * day - wy * dax;
      if (den < 0) begin
        den = -den;
        tn  = -tn;
        un  = -un;
      end
      return (tn >= 0) && (tn <= den) && (un >= 0) && (un <= den);
    end
    // Parallel or degenerate: both b endpoints must lie on the line of a,
    // or, if a is a single point, that point must lie on the line of b.
    if (dax != 0 || day != 0) begin
      if (dax * wy - day * wx != 0) return 1'b0;
      if (dax * (by1 - ay0) - day * (bx1 - ax0) != 0) return 1'b0;
    end else if (dbx != 0 || dby != 0) begin
      if (dbx * (ay0 - by0) - dby * (ax0 - bx0) != 0) return 1'b0;
    end
    return spans_meet(ax0, ax1, bx0, bx1) && spans_meet(ay0, ay1, by0, by1);
  endfunction

  function void note_pair(seg_pair_t p);
    expected_hits.push_back(predict_hit(p));
    pairs_seen++;
  endfunction

  function void check_result(logic [7:0] beat);
    bit want;
    if (expected_hits.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("[%0t] result beat %b arrived with no pair outstanding", $time, beat);
      return;
    end
    want = expected_hits.pop_front();
    if (want) hits_seen++;
    // The hit flag sits in bit 0 and the seven bits above it must stay zero.
    if (beat[0] !== want || beat[7:1] !== 7'd0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("[%0t] hit mismatch: expected hit=%0b, got tdata=%b", $time, want, beat);
    end
  endfunction
endclass

module tb_segment_intersection_test;

  localparam int          COORD_BITS    = 16;
  localparam int          C_MIN         = -32768;
  localparam int          C_MAX         = 32767;
  localparam int unsigned RANDOM_PAIRS  = 926;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned DRAIN_CYCLES  = 12;
  localparam int unsigned CYCLE_LIMIT   = 200000;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      s_axis_tvalid;
  logic                      s_axis_tready;
  // From bit 0 up: seg_a_x0, seg_a_y0, seg_a_x1, seg_a_y1,
  // seg_b_x0, seg_b_y0, seg_b_x1, seg_b_y1.
  logic [8*COORD_BITS-1:0]   s_axis_tdata;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready;
  // From bit 0 up: hit, then seven zero bits.
  logic [7:0]                m_axis_tdata;

  intersect_scoreboard sb = new();

  // Shared between the sender and the receiver. no_idle switches off the
  // random gaps on both sides for whole stretches of the random part, and
  // hold_off_req asks the receiver for one long stall. Only the sender
  // writes these two; held_cycles and cycle_count each have one writer too.
  bit          no_idle;
  bit          hold_off_req;
  int unsigned held_cycles;
  int unsigned cycle_count;

  segment_intersection_test #(
    .COORD_BITS(COORD_BITS)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: a correct run needs well under a tenth of this, even with
  // every gap and stall at its longest.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Both handshakes are observed at the rising edge. Inputs are noted before
  // outputs are checked so that the queue is always up to date.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_pair(seg_pair_t'(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    end
  end

  // Builds a pair from integer coordinates, keeping the low 16 bits of each.
  function automatic seg_pair_t mk(int ax0, int ay0, int ax1, int ay1,
                                   int bx0, int by0, int bx1, int by1);
    seg_pair_t p;
    p.a_x0 = 16'(ax0); p.a_y0 = 16'(ay0); p.a_x1 = 16'(ax1); p.a_y1 = 16'(ay1);
    p.b_x0 = 16'(bx0); p.b_y0 = 16'(by0); p.b_x1 = 16'(bx1); p.b_y1 = 16'(by1);
    return p;
  endfunction

  // Uniform value in [-r, r].
  function automatic int spread(int r);
    return int'($urandom_range(0, 2 * r)) - r;
  endfunction

  // Values at and next to the ends of the coordinate range and around zero.
  function automatic int pick_edge();
    case ($urandom_range(0, 6))
      0:       return C_MIN;
      1:       return C_MIN + 1;
      2:       return -1;
      3:       return 0;
      4:       return 1;
      5:       return C_MAX - 1;
      default: return C_MAX;
    endcase
  endfunction

  // Random geometry. Fully random pairs toggle every bit but almost never
  // touch, so most draws are shaped to land near the decision boundaries:
  // small boxes, collinear runs, points on or just off a segment, shared
  // endpoints and parallel neighbors.
  function automatic seg_pair_t random_pair();
    int        kind, px, py, dx, dy, k0, k1, k2, k3, qx, qy;
    seg_pair_t p;
    kind = $urandom_range(0, 99);
    if (kind < 20) begin
      p = seg_pair_t'({$urandom, $urandom, $urandom, $urandom});
    end else if (kind < 45) begin
      p = mk(spread(8), spread(8), spread(8), spread(8),
             spread(8), spread(8), spread(8), spread(8));
    end else if (kind < 60) begin
      // All four endpoints on one line through (px,py) with direction (dx,dy).
      px = spread(1000); py = spread(1000);
      dx = spread(3);    dy = spread(3);
      k0 = spread(6); k1 = spread(6); k2 = spread(6); k3 = spread(6);
      p = mk(px + k0 * dx, py + k0 * dy, px + k1 * dx, py + k1 * dy,
             px + k2 * dx, py + k2 * dy, px + k3 * dx, py + k3 * dy);
    end else if (kind < 70) begin
      p = mk(pick_edge(), pick_edge(), pick_edge(), pick_edge(),
             pick_edge(), pick_edge(), pick_edge(), pick_edge());
    end else if (kind < 80) begin
      // A point on the segment, one step past its end, or nudged off the line.
      px = spread(500); py = spread(500);
      dx = spread(4);   dy = spread(4);
      k0 = $urandom_range(0, 5);
      k1 = $urandom_range(0, k0 + 1);
      qx = px + k1 * dx + (($urandom_range(0, 3) == 0) ? spread(1) : 0);
      qy = py + k1 * dy;
      if ($urandom_range(0, 1))
        p = mk(px, py, px + k0 * dx, py + k0 * dy, qx, qy, qx, qy);
      else
        p = mk(qx, qy, qx, qy, px, py, px + k0 * dx, py + k0 * dy);
    end else if (kind < 90) begin
      // Segment b starts on one end of segment a.
      px = int'($urandom); py = int'($urandom);
      qx = int'($urandom); qy = int'($urandom);
      k0 = int'($urandom); k1 = int'($urandom);
      if ($urandom_range(0, 1))
        p = mk(px, py, qx, qy, qx, qy, k0, k1);
      else
        p = mk(px, py, qx, qy, px, py, k0, k1);
    end else begin
      // Segment b is a copy of a, shifted by a small vector.
      px = spread(1000); py = spread(1000);
      dx = spread(20);   dy = spread(20);
      qx = spread(3);    qy = spread(3);
      p = mk(px, py, px + dx, py + dy, px + qx, py + qy, px + dx + qx, py + dy + qy);
    end
    return p;
  endfunction

  // Offers one pair after an optional gap and returns at the falling edge
  // after it was taken. Called and returning at a falling edge, so tvalid
  // gets exactly one assignment per edge.
  task automatic send_pair(input seg_pair_t p, input int unsigned gap);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= p;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // Receiver: before every beat it stalls for a random number of cycles (none
  // while no_idle is set), or for one long stretch when asked, so that the
  // pipeline backs up and the block has to drop s_axis_tready.
  initial begin : result_sink
    int unsigned stall;
    bit          hold_taken;
    hold_taken    = 1'b0;
    m_axis_tready = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      if (hold_off_req && !hold_taken) begin
        stall        = HOLD_CYCLES;
        hold_taken   = 1'b1;
        held_cycles += HOLD_CYCLES;
      end else begin
        stall = no_idle ? 0 : $urandom_range(0, 15);
      end
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      @(negedge clk_i);
    end
  end

  initial begin : stimulus
    seg_pair_t corner_pairs[$];
    int unsigned i;

    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    no_idle       = 1'b0;
    hold_off_req  = 1'b0;

    // Proper crossings, with the determinant of either sign.
    corner_pairs.push_back(mk(0, 0, 10, 10, 0, 10, 10, 0));
    corner_pairs.push_back(mk(0, 0, 10, 10, 10, 0, 0, 10));
    // An endpoint touching the middle of the other segment, and a shared endpoint.
    corner_pairs.push_back(mk(0, 0, 10, 0, 5, 0, 5, 7));
    corner_pairs.push_back(mk(0, 0, 4, 4, 4, 4, 9, 1));
    // Lines that cross on segment b but outside segment a.
    corner_pairs.push_back(mk(0, 0, 2, 2, 0, 4, 4, 3));
    // Parallel but on different lines.
    corner_pairs.push_back(mk(0, 0, 10, 0, 0, 1, 10, 1));
    // Collinear: overlapping, apart, touching at one point, given back to front.
    corner_pairs.push_back(mk(0, 0, 10, 0, 5, 0, 15, 0));
    corner_pairs.push_back(mk(0, 0, 4, 4, 5, 5, 9, 9));
    corner_pairs.push_back(mk(0, 0, 4, 4, 4, 4, 9, 9));
    corner_pairs.push_back(mk(10, 0, 0, 0, 15, 0, 10, 0));
    // A point on the segment, on its line but past the end, and off the line.
    corner_pairs.push_back(mk(0, 0, 6, 3, 2, 1, 2, 1));
    corner_pairs.push_back(mk(0, 0, 6, 3, 8, 4, 8, 4));
    corner_pairs.push_back(mk(0, 0, 6, 3, 2, 2, 2, 2));
    // The first segment collapsed to a point lying on the second.
    corner_pairs.push_back(mk(3, 3, 3, 3, 0, 0, 6, 6));
    // Two points, equal and different.
    corner_pairs.push_back(mk(7, -7, 7, -7, 7, -7, 7, -7));
    corner_pairs.push_back(mk(7, -7, 7, -7, -7, 7, -7, 7));
    // Vertical against horizontal.
    corner_pairs.push_back(mk(0, -5, 0, 5, -5, 0, 5, 0));
    // Full-range coordinates: diagonals, parallel edges, collinear on x = max.
    corner_pairs.push_back(mk(C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MAX, C_MAX, C_MIN));
    corner_pairs.push_back(mk(C_MIN, C_MIN, C_MAX, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX));
    corner_pairs.push_back(mk(C_MAX, C_MIN, C_MAX, C_MAX, C_MAX, 0, C_MAX, C_MAX));
    corner_pairs.push_back(mk(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN));
    corner_pairs.push_back(mk(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX));
    corner_pairs.push_back(mk(C_MIN, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, C_MAX));
    // Nearly parallel long segments, which push the products to their widest.
    corner_pairs.push_back(mk(C_MIN, C_MIN, C_MAX, C_MAX - 1, C_MIN, C_MIN + 1, C_MAX, C_MAX));

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (corner_pairs[k]) send_pair(corner_pairs[k], $urandom_range(0, 15));

    // Random part. Every third stretch of 64 pairs runs without gaps on
    // either side, and partway through the receiver holds off for a long time
    // while pairs keep coming.
    for (i = 0; i < RANDOM_PAIRS; i++) begin
      no_idle = ((i / 64) % 3 == 1);
      if (i == 300) hold_off_req = 1'b1;
      send_pair(random_pair(), no_idle ? 0 : $urandom_range(0, 15));
    end
    s_axis_tvalid <= 1'b0;

    // Wait for the last results, then a few more cycles to catch any extra beat.
    while (sb.expected_hits.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.expected_hits.size() != 0) sb.mismatches++;

    $display("Checked %0d segment pairs (%0d hits, %0d misses): corner cases, then random,",
             sb.pairs_seen, sb.hits_seen, sb.pairs_seen - sb.hits_seen);
    $display("collinear, touching and full-range geometry; output held off %0d cycles; %0d errors.",
             held_cycles, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
